// ----- rtl/msrd_pkg.sv -----
// Package for the max-sample raster downscaler: word types, register indexes and fixed widths.
// Used by the divider, the core and the testbench; it depends on nothing else.
`timescale 1ns / 1ps

package msrd_pkg;

    // Widths fixed by the word formats.
    localparam int VALUE_W = 32;   // elevation sample and view value
    localparam int POS_W   = 8;    // row and column fields of a command word
    localparam int CFG_W   = 9;    // configuration registers
    localparam int COORD_W = 9;    // source coordinates computed for a query
    localparam int PROD_W  = 18;   // coordinate times scale products
    localparam int DIV_RADIX_BITS = 2;                  // quotient bits per divider cycle
    localparam int DIV_STEPS = PROD_W / DIV_RADIX_BITS; // divider steps per division

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROWS_IN_USE = 2'd0;
    localparam logic [1:0] CFG_COLS_IN_USE = 2'd1;
    localparam logic [1:0] CFG_SOURCE_SIZE = 2'd2;
    localparam logic [1:0] CFG_TARGET_SIZE = 2'd3;

    localparam logic [CFG_W-1:0] CFG_RESET_VALUE = 9'd256;

    // Command kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [POS_W-1:0]          row;
        logic [POS_W-1:0]          col;
        logic signed [VALUE_W-1:0] sample;
    } cmd_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] view_value;
        logic                      outside_view;
    } result_word_t;

    // Status returned by the divider.
    typedef struct packed {
        logic               done;
        logic [PROD_W-1:0]  quotient;
        logic [CFG_W-1:0]   remainder;
    } div_res_t;

endpackage

// ----- rtl/msrd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps

module msrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/msrd_div.sv -----
// Iterative restoring divider, two quotient bits per cycle, for the source coordinate mapping.
// Depends on msrd_pkg for widths and the result struct.
`timescale 1ns / 1ps

module msrd_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [msrd_pkg::PROD_W-1:0]  dividend,
    input  logic [msrd_pkg::CFG_W-1:0]   divisor,
    output msrd_pkg::div_res_t           res
);

    localparam int CNT_W = $clog2(msrd_pkg::DIV_STEPS);
    localparam int DW    = msrd_pkg::PROD_W;
    localparam int SW    = msrd_pkg::CFG_W;

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    quo_reg;
    logic [SW-1:0]    rem_reg;
    logic [SW-1:0]    dvs_reg;
    logic [DW-1:0]    quo_next;
    logic [SW-1:0]    rem_next;

    // Two dependent shift-compare-subtract steps per cycle.
    always_comb
    begin
        logic [SW:0] trial;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int k = 0; k < msrd_pkg::DIV_RADIX_BITS; k++)
        begin
            trial    = {rem_next, quo_next[DW-1]};
            quo_next = {quo_next[DW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next    = SW'(trial - {1'b0, dvs_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[SW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(msrd_pkg::DIV_STEPS - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

// ----- rtl/max_sample_raster_downscale_core.sv -----
// Top level of the max-sample raster downscaler: command decode, query sequencer and raster store.
// Depends on msrd_pkg, msrd_ram and msrd_div.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Word
// -------   ---------  ---------------------  ----------------------------------------
// command   in         start high, busy low   cmd    (kind, row, col, sample)
// result    out        done, one cycle        result (view_value, outside_view)
// config    in         cfg_we                 cfg_addr selects, cfg_wdata (9 bits)
//
// A sample write leaves busy low, so writes may stream every cycle while no query holds busy.
// A query holds busy high until its result word is on the ports, so the next command can
// be taken at the edge that takes that word. A query outside the view passes only the
// check and the output register; when the view is the raster itself it passes the check,
// four reads through the single read port of the raster store, the fold of the last corner
// and the output register. A downscaled query also passes the divide state: the divider
// load, its nine steps of two quotient bits, and the cycle in which its done flag is seen.
// Reset returns every configuration register to 256 and the sequencer to idle; the store
// contents are left as they are. The receiver cannot stall, so done is a single-cycle strobe.

module max_sample_raster_downscale_core #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  msrd_pkg::cmd_word_t              cmd,
    output logic                             busy,
    output logic                             done,
    output msrd_pkg::result_word_t           result,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_addr,
    input  logic [msrd_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    // Wide enough to compare a 9-bit register against the store dimensions.
    localparam int LIM_W  = ($clog2(MAX_ROWS + 1) > msrd_pkg::CFG_W) ?
                            $clog2(MAX_ROWS + 1) : msrd_pkg::CFG_W;
    localparam int CLIM_W = ($clog2(MAX_COLS + 1) > msrd_pkg::CFG_W) ?
                            $clog2(MAX_COLS + 1) : msrd_pkg::CFG_W;
    localparam int CW     = msrd_pkg::CFG_W;
    localparam int KW     = msrd_pkg::COORD_W;
    localparam int PW     = msrd_pkg::PROD_W;
    localparam int VW     = msrd_pkg::VALUE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_READ,
        ST_DRAIN
    } state_t;

    // Configuration registers.
    logic [CW-1:0] rows_reg;
    logic [CW-1:0] cols_reg;
    logic [CW-1:0] src_size_reg;
    logic [CW-1:0] tgt_size_reg;

    // Effective configuration: sizes capped at the store, zero scales taken as one.
    logic [CW-1:0] nr;
    logic [CW-1:0] nc;
    logic [CW-1:0] src;
    logic [CW-1:0] tgt;
    logic          downscale;

    // Sequencer state and query working registers.
    state_t                 state_reg, state_next;
    logic [msrd_pkg::POS_W-1:0] r_reg, r_next;
    logic [msrd_pkg::POS_W-1:0] c_reg, c_next;
    logic [PW-1:0]          pr_reg, pr_next;
    logic [PW-1:0]          pc_reg, pc_next;
    logic [PW-1:0]          limr_reg, limr_next;
    logic [PW-1:0]          limc_reg, limc_next;
    logic [KW-1:0]          rf_reg, rf_next;
    logic [KW-1:0]          rc_reg, rc_next;
    logic [KW-1:0]          cf_reg, cf_next;
    logic [KW-1:0]          cc_reg, cc_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic                   rd_first_reg, rd_first_next;
    logic                   rd_in_reg, rd_in_next;
    logic signed [VW-1:0]   acc_reg, acc_next;
    logic                   done_reg, done_next;
    msrd_pkg::result_word_t result_reg, result_next;

    // Store access.
    logic                   accept;
    logic                   wr_en;
    logic [ADDR_W-1:0]      waddr;
    logic [ADDR_W-1:0]      raddr;
    logic [SAMPLE_BITS-1:0] rdata;
    logic signed [SAMPLE_BITS-1:0] rdata_s;
    logic [KW-1:0]          rsel;
    logic [KW-1:0]          csel;
    logic                   sel_inside;
    logic signed [VW-1:0]   in_val;
    logic signed [VW-1:0]   fold_val;
    logic                   flag_row;
    logic                   flag_col;

    // Divider interface.
    logic               div_start;
    msrd_pkg::div_res_t div_row_res;
    msrd_pkg::div_res_t div_col_res;

    // ------------------------------------------------------------------
    // Effective configuration.
    // ------------------------------------------------------------------
    assign nr  = (LIM_W'(rows_reg) > LIM_W'(MAX_ROWS)) ? CW'(MAX_ROWS) : rows_reg;
    assign nc  = (CLIM_W'(cols_reg) > CLIM_W'(MAX_COLS)) ? CW'(MAX_COLS) : cols_reg;
    assign src = (src_size_reg == '0) ? CW'(1) : src_size_reg;
    assign tgt = (tgt_size_reg == '0) ? CW'(1) : tgt_size_reg;
    assign downscale = (src > tgt);

    // ------------------------------------------------------------------
    // Command acceptance and sample writes. A write lands in the store at
    // the edge that accepts it, and queries only start reading once busy is
    // raised, so reads never overlap a write to the same entry.
    // ------------------------------------------------------------------
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && (cmd.kind == msrd_pkg::KIND_WRITE)
                    && (32'(cmd.row) < MAX_ROWS) && (32'(cmd.col) < MAX_COLS);
    assign waddr  = ADDR_W'(ADDR_W'(cmd.row) * ADDR_W'(MAX_COLS) + ADDR_W'(cmd.col));

    msrd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (cmd.sample[SAMPLE_BITS-1:0]),
        .raddr (raddr),
        .rdata (rdata)
    );

    // ------------------------------------------------------------------
    // Coordinate mapping. Both dividers run together on row and column.
    // ------------------------------------------------------------------
    msrd_div u_div_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pr_reg),
        .divisor  (tgt),
        .res      (div_row_res)
    );

    msrd_div u_div_col (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pc_reg),
        .divisor  (tgt),
        .res      (div_col_res)
    );

    // ------------------------------------------------------------------
    // Read addressing: the counter walks the four corners, row bit high,
    // column bit low. A corner beyond the loaded raster reads as zero.
    // ------------------------------------------------------------------
    assign rsel       = cnt_reg[1] ? rc_reg : rf_reg;
    assign csel       = cnt_reg[0] ? cc_reg : cf_reg;
    assign sel_inside = (rsel < nr) && (csel < nc);
    assign raddr      = ADDR_W'(ADDR_W'(rsel) * ADDR_W'(MAX_COLS) + ADDR_W'(csel));

    assign rdata_s  = rdata;
    assign in_val   = rd_in_reg ? VW'(rdata_s) : '0;
    assign fold_val = (rd_first_reg || (in_val > acc_reg)) ? in_val : acc_reg;

    // A view row r exists exactly when (r + 1) * source <= rows * target,
    // which avoids dividing to find the view size.
    assign flag_row = downscale ? ((pr_reg + PW'(src)) > limr_reg) : (KW'(r_reg) >= nr);
    assign flag_col = downscale ? ((pc_reg + PW'(src)) > limc_reg) : (KW'(c_reg) >= nc);

    // ------------------------------------------------------------------
    // Query sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        pr_next       = pr_reg;
        pc_next       = pc_reg;
        limr_next     = limr_reg;
        limc_next     = limc_reg;
        rf_next       = rf_reg;
        rc_next       = rc_reg;
        cf_next       = cf_reg;
        cc_next       = cc_reg;
        cnt_next      = cnt_reg;
        rd_pend_next  = 1'b0;
        rd_first_next = rd_first_reg;
        rd_in_next    = rd_in_reg;
        acc_next      = rd_pend_reg ? fold_val : acc_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        div_start     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.kind == msrd_pkg::KIND_QUERY))
                begin
                    r_next     = cmd.row;
                    c_next     = cmd.col;
                    pr_next    = PW'(cmd.row) * PW'(src);
                    pc_next    = PW'(cmd.col) * PW'(src);
                    limr_next  = PW'(nr) * PW'(tgt);
                    limc_next  = PW'(nc) * PW'(tgt);
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (flag_row || flag_col)
                begin
                    done_next                = 1'b1;
                    result_next.view_value   = '0;
                    result_next.outside_view = 1'b1;
                    state_next               = ST_IDLE;
                end
                else if (downscale)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    rf_next    = KW'(r_reg);
                    rc_next    = KW'(r_reg);
                    cf_next    = KW'(c_reg);
                    cc_next    = KW'(c_reg);
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
            end

            ST_DIV:
            begin
                if (div_row_res.done)
                begin
                    // The query passed the view check, so the floor lies
                    // inside the loaded raster and fits the coordinate width.
                    rf_next    = div_row_res.quotient[KW-1:0];
                    cf_next    = div_col_res.quotient[KW-1:0];
                    rc_next    = div_row_res.quotient[KW-1:0]
                                 + KW'(div_row_res.remainder != '0);
                    cc_next    = div_col_res.quotient[KW-1:0]
                                 + KW'(div_col_res.remainder != '0);
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                rd_pend_next  = 1'b1;
                rd_first_next = (cnt_reg == 2'd0);
                rd_in_next    = sel_inside;
                cnt_next      = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                // The last corner arrives now and is folded straight into the word.
                done_next                = 1'b1;
                result_next.view_value   = fold_val;
                result_next.outside_view = 1'b0;
                state_next               = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
            rows_reg     <= msrd_pkg::CFG_RESET_VALUE;
            cols_reg     <= msrd_pkg::CFG_RESET_VALUE;
            src_size_reg <= msrd_pkg::CFG_RESET_VALUE;
            tgt_size_reg <= msrd_pkg::CFG_RESET_VALUE;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_pend_next;
            done_reg    <= done_next;
            result_reg  <= result_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    msrd_pkg::CFG_ROWS_IN_USE: rows_reg     <= cfg_wdata;
                    msrd_pkg::CFG_COLS_IN_USE: cols_reg     <= cfg_wdata;
                    msrd_pkg::CFG_SOURCE_SIZE: src_size_reg <= cfg_wdata;
                    msrd_pkg::CFG_TARGET_SIZE: tgt_size_reg <= cfg_wdata;
                    default:                   rows_reg     <= rows_reg;
                endcase
            end
        end
    end

    // Working registers of the current query need no reset.
    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        c_reg        <= c_next;
        pr_reg       <= pr_next;
        pc_reg       <= pc_next;
        limr_reg     <= limr_next;
        limc_reg     <= limc_next;
        rf_reg       <= rf_next;
        rc_reg       <= rc_next;
        cf_reg       <= cf_next;
        cc_reg       <= cc_next;
        rd_first_reg <= rd_first_next;
        rd_in_reg    <= rd_in_next;
        acc_reg      <= acc_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- dv/max_sample_raster_downscale_core_tb.sv -----
// Self-checking testbench for max_sample_raster_downscale_core: directed and random command words,
// with each result word checked against a behavioural model of the max-pooled view.
// Depends on msrd_pkg and the core RTL only.
`timescale 1ns / 1ps

module max_sample_raster_downscale_core_tb;

    localparam int     CLK_PERIOD    = 10;
    localparam int     RESET_CYCLES  = 11;
    localparam int     RASTER_SIDE   = 256;
    // Stimulus stops once this many command words have been taken by the core.
    localparam int     TOTAL_WORDS   = 1000;
    // In the last stretch of the run, words are sent with no random gaps before them.
    localparam int     CALM_WORDS    = 150;
    // Settling time after the last answer, longer than a whole downscaled query.
    localparam int     SETTLE_CYCLES = 40;
    localparam longint TIMEOUT_NS    = 5_000_000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    msrd_pkg::cmd_word_t       cmd;
    logic                      busy;
    logic                      done;
    msrd_pkg::result_word_t    result;
    logic                      cfg_we;
    logic [1:0]                cfg_addr;
    logic [msrd_pkg::CFG_W-1:0] cfg_wdata;

    // Mirror of the raster store, with a flag per entry so that no query is ever made
    // that would read an entry the core has never been given.
    logic signed [msrd_pkg::VALUE_W-1:0] raster_mirror [RASTER_SIDE*RASTER_SIDE];
    bit                                  raster_written [RASTER_SIDE*RASTER_SIDE];
    bit                                  hole_seen;

    // Shadow copies of the four configuration registers.
    logic [msrd_pkg::CFG_W-1:0] rows_loaded;
    logic [msrd_pkg::CFG_W-1:0] cols_loaded;
    logic [msrd_pkg::CFG_W-1:0] scale_src;
    logic [msrd_pkg::CFG_W-1:0] scale_tgt;

    // View pixels predicted for queries that have been taken but not yet answered.
    msrd_pkg::result_word_t pending_views [$];
    int                     fail_count;
    int                     words_sent;

    max_sample_raster_downscale_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Behavioural model of the view
    // ------------------------------------------------------------------

    // Works out the effective loaded size, the scale terms and the view size from the
    // shadow registers. Loaded sizes are capped at the store size, and a zero scale term
    // behaves as one.
    function automatic void view_extent(output int unsigned nr, nc, src, tgt, vr, vc);
        nr  = (rows_loaded > RASTER_SIDE) ? RASTER_SIDE : rows_loaded;
        nc  = (cols_loaded > RASTER_SIDE) ? RASTER_SIDE : cols_loaded;
        src = (scale_src == '0) ? 1 : scale_src;
        tgt = (scale_tgt == '0) ? 1 : scale_tgt;
        if (src <= tgt)
        begin
            vr = nr;
            vc = nc;
        end
        else
        begin
            vr = nr * tgt / src;
            vc = nc * tgt / src;
        end
    endfunction

    // A source position outside the loaded raster reads as zero. Reading a loaded entry
    // that was never written raises hole_seen so that the stimulus can steer clear of it.
    function automatic logic signed [msrd_pkg::VALUE_W-1:0] mirror_sample(int unsigned r, c,
                                                                          nr, nc);
        if (r >= nr || c >= nc)
            return '0;
        if (!raster_written[r*RASTER_SIDE + c])
            hole_seen = 1'b1;
        return raster_mirror[r*RASTER_SIDE + c];
    endfunction

    // Predicts the result word for a query of view pixel (r, c). When the view is
    // downscaled, the source position r*src/tgt is taken as floor and ceiling in both
    // directions and the largest of the four samples wins.
    function automatic msrd_pkg::result_word_t pooled_view_pixel(
        input logic [msrd_pkg::POS_W-1:0] r,
        input logic [msrd_pkg::POS_W-1:0] c);
        int unsigned                         nr, nc, src, tgt, vr, vc;
        int unsigned                         pr, pc, rf, cf, rcl, ccl;
        logic signed [msrd_pkg::VALUE_W-1:0] best, cand;
        msrd_pkg::result_word_t              res;
        view_extent(nr, nc, src, tgt, vr, vc);
        res = '0;
        if (32'(r) >= vr || 32'(c) >= vc)
        begin
            res.outside_view = 1'b1;
            return res;
        end
        if (src <= tgt)
        begin
            res.view_value = mirror_sample(32'(r), 32'(c), nr, nc);
        end
        else
        begin
            pr   = 32'(r) * src;
            pc   = 32'(c) * src;
            rf   = pr / tgt;
            cf   = pc / tgt;
            rcl  = rf + (((pr % tgt) != 0) ? 1 : 0);
            ccl  = cf + (((pc % tgt) != 0) ? 1 : 0);
            best = mirror_sample(rf, cf, nr, nc);
            cand = mirror_sample(rf, ccl, nr, nc);
            if (cand > best) best = cand;
            cand = mirror_sample(rcl, cf, nr, nc);
            if (cand > best) best = cand;
            cand = mirror_sample(rcl, ccl, nr, nc);
            if (cand > best) best = cand;
            res.view_value = best;
        end
        return res;
    endfunction

    // Random elevation samples, weighted towards the extremes of the signed range and values near zero.
    function automatic logic signed [msrd_pkg::VALUE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(msrd_pkg::VALUE_W-1){1'b0}}};
            1:       return {1'b0, {(msrd_pkg::VALUE_W-1){1'b1}}};
            2:       return -$signed(msrd_pkg::VALUE_W'($urandom_range(1, 16)));
            3:       return msrd_pkg::VALUE_W'($urandom_range(0, 16));
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offers one command word and waits until the core takes it. Outside the calm
    // stretch at the end, a random gap may come first, with junk on the command bus. The
    // model is updated at the edge that takes the word.
    task automatic send_word(input msrd_pkg::cmd_word_t w);
        int                  gap;
        int unsigned         idx;
        msrd_pkg::cmd_word_t junk;
        if (words_sent < TOTAL_WORDS - CALM_WORDS && $urandom_range(0, 3) == 0)
        begin
            gap         = $urandom_range(1, 4);
            junk.kind   = 1'($urandom_range(0, 1));
            junk.row    = msrd_pkg::POS_W'($urandom);
            junk.col    = msrd_pkg::POS_W'($urandom);
            junk.sample = $urandom;
            @(negedge clk);
            start <= 1'b0;
            cmd   <= junk;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= w;
        do @(posedge clk); while (busy);
        words_sent++;
        if (w.kind == msrd_pkg::KIND_WRITE)
        begin
            idx                 = w.row * RASTER_SIDE + w.col;
            raster_mirror[idx]  = w.sample;
            raster_written[idx] = 1'b1;
        end
        else
        begin
            pending_views.push_back(pooled_view_pixel(w.row, w.col));
        end
    endtask

    task automatic write_pixel(input int unsigned r, c,
                               input logic signed [msrd_pkg::VALUE_W-1:0] s);
        msrd_pkg::cmd_word_t w;
        w.kind   = msrd_pkg::KIND_WRITE;
        w.row    = msrd_pkg::POS_W'(r);
        w.col    = msrd_pkg::POS_W'(c);
        w.sample = s;
        send_word(w);
    endtask

    task automatic query_pixel(input int unsigned r, c);
        msrd_pkg::cmd_word_t w;
        w.kind   = msrd_pkg::KIND_QUERY;
        w.row    = msrd_pkg::POS_W'(r);
        w.col    = msrd_pkg::POS_W'(c);
        w.sample = $urandom;
        send_word(w);
    endtask

    // Holds the command channel off until every predicted word has come back, then lets
    // the core settle. Writes produce no result word, so the settling time covers any
    // work still in flight after the last answer.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_views.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        case (idx)
            msrd_pkg::CFG_ROWS_IN_USE: rows_loaded = msrd_pkg::CFG_W'(val);
            msrd_pkg::CFG_COLS_IN_USE: cols_loaded = msrd_pkg::CFG_W'(val);
            msrd_pkg::CFG_SOURCE_SIZE: scale_src   = msrd_pkg::CFG_W'(val);
            msrd_pkg::CFG_TARGET_SIZE: scale_tgt   = msrd_pkg::CFG_W'(val);
            default:                   ;
        endcase
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= msrd_pkg::CFG_W'(val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Registers only ever change while the core is idle.
    task automatic apply_settings(input int unsigned rows, cols, src, tgt);
        drain_results();
        write_reg(msrd_pkg::CFG_ROWS_IN_USE, rows);
        write_reg(msrd_pkg::CFG_COLS_IN_USE, cols);
        write_reg(msrd_pkg::CFG_SOURCE_SIZE, src);
        write_reg(msrd_pkg::CFG_TARGET_SIZE, tgt);
    endtask

    // Writes every entry of the loaded raster that has not been written yet, so that any
    // query under the current settings reads only known samples.
    task automatic fill_loaded_raster();
        int unsigned nr, nc, src, tgt, vr, vc;
        view_extent(nr, nc, src, tgt, vr, vc);
        for (int unsigned r = 0; r < nr; r++)
            for (int unsigned c = 0; c < nc; c++)
                if (!raster_written[r*RASTER_SIDE + c])
                    write_pixel(r, c, random_sample());
    endtask

    // One phase of random traffic under fixed settings: mostly queries inside the view,
    // some anywhere in the coordinate range, and overwrites of loaded and stray entries.
    task automatic run_random_phase(input int unsigned rows, cols, src, tgt,
                                    input int count);
        int unsigned         nr, nc, src_e, tgt_e, vr, vc;
        int                  pick;
        msrd_pkg::cmd_word_t w;
        apply_settings(rows, cols, src, tgt);
        fill_loaded_raster();
        view_extent(nr, nc, src_e, tgt_e, vr, vc);
        for (int i = 0; i < count && words_sent < TOTAL_WORDS; i++)
        begin
            pick     = $urandom_range(0, 99);
            w.sample = random_sample();
            w.row    = msrd_pkg::POS_W'($urandom);
            w.col    = msrd_pkg::POS_W'($urandom);
            if (pick < 75)
            begin
                w.kind = msrd_pkg::KIND_QUERY;
                if (pick < 65 && vr > 0 && vc > 0)
                begin
                    w.row = msrd_pkg::POS_W'($urandom_range(0, vr - 1));
                    w.col = msrd_pkg::POS_W'($urandom_range(0, vc - 1));
                end
            end
            else
            begin
                w.kind = msrd_pkg::KIND_WRITE;
                if (pick < 93 && nr > 0 && nc > 0)
                begin
                    w.row = msrd_pkg::POS_W'($urandom_range(0, nr - 1));
                    w.col = msrd_pkg::POS_W'($urandom_range(0, nc - 1));
                end
            end
            // A query that would touch an unwritten entry is turned into a write.
            if (w.kind == msrd_pkg::KIND_QUERY)
            begin
                hole_seen = 1'b0;
                void'(pooled_view_pixel(w.row, w.col));
                if (hole_seen)
                    w.kind = msrd_pkg::KIND_WRITE;
            end
            send_word(w);
            // Now and then the sender waits for every outstanding answer.
            if ($urandom_range(0, 49) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: the view is the full raster, so each query returns one sample.
    task automatic test_reset_defaults();
        write_pixel(0, 0, {1'b1, {(msrd_pkg::VALUE_W-1){1'b0}}});
        write_pixel(255, 255, {1'b0, {(msrd_pkg::VALUE_W-1){1'b1}}});
        write_pixel(0, 255, -1);
        write_pixel(255, 0, 0);
        query_pixel(0, 0);
        query_pixel(255, 255);
        query_pixel(0, 255);
        query_pixel(255, 0);
    endtask

    // A 3 by 3 raster at a scale of 3/2 gives a 2 by 2 view in which pixel (1,1) pools a
    // full square of four neighbours; pixels beyond the view come back flagged.
    task automatic test_downscale_pooling();
        apply_settings(3, 3, 3, 2);
        fill_loaded_raster();
        query_pixel(0, 0);
        query_pixel(0, 1);
        query_pixel(1, 0);
        query_pixel(1, 1);
        query_pixel(2, 0);
        query_pixel(0, 2);
    endtask

    // Empty loaded raster, zero scale terms in both places, and a zero target alone.
    task automatic test_degenerate_settings();
        apply_settings(0, 3, 3, 2);
        query_pixel(0, 0);
        apply_settings(3, 3, 0, 0);
        query_pixel(2, 2);
        apply_settings(3, 3, 3, 0);
        query_pixel(0, 0);
        query_pixel(1, 0);
    endtask

    // Register extremes: loaded sizes beyond the store, a full-width row and column,
    // the largest scale terms, and an empty view.
    task automatic test_large_extents();
        run_random_phase(511, 1, 1, 1, 30);
        run_random_phase(1, 256, 256, 256, 30);
        run_random_phase(12, 12, 511, 200, 30);
        run_random_phase(9, 9, 511, 511, 30);
        run_random_phase(0, 7, 5, 2, 20);
    endtask

    // Random small rasters, mostly downscaled by up to a factor of three, with a
    // share of arbitrary scale settings.
    task automatic test_random_settings();
        int unsigned rows, cols, src, tgt;
        while (words_sent < TOTAL_WORDS)
        begin
            rows = $urandom_range(1, 12);
            cols = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0)
            begin
                src = $urandom_range(0, 511);
                tgt = $urandom_range(0, 511);
            end
            else
            begin
                tgt = $urandom_range(1, 40);
                src = tgt + $urandom_range(1, 2 * tgt);
            end
            run_random_phase(rows, cols, src, tgt, 60);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking: every result word is matched against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        msrd_pkg::result_word_t want;
        if (rst_n && done)
        begin
            if (pending_views.size() == 0)
            begin
                $display("%0t: result word with nothing expected, view_value %0d outside_view %0b",
                         $time, result.view_value, result.outside_view);
                fail_count++;
            end
            else
            begin
                want = pending_views.pop_front();
                if (result.view_value !== want.view_value)
                begin
                    $display("%0t: view_value mismatch, expected %0d, actual %0d",
                             $time, want.view_value, result.view_value);
                    fail_count++;
                end
                if (result.outside_view !== want.outside_view)
                begin
                    $display("%0t: outside_view mismatch, expected %0b, actual %0b",
                             $time, want.outside_view, result.outside_view);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_we      = 1'b0;
        cfg_addr    = msrd_pkg::CFG_ROWS_IN_USE;
        cfg_wdata   = '0;
        rows_loaded = msrd_pkg::CFG_RESET_VALUE;
        cols_loaded = msrd_pkg::CFG_RESET_VALUE;
        scale_src   = msrd_pkg::CFG_RESET_VALUE;
        scale_tgt   = msrd_pkg::CFG_RESET_VALUE;
        fail_count  = 0;
        words_sent  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_downscale_pooling();
        test_degenerate_settings();
        test_large_extents();
        test_random_settings();

        // Wait for the last answers and give any stray word time to show up.
        drain_results();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guard against a hung handshake or missing result words.
    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timed out with %0d result words outstanding",
                 $time, pending_views.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/msrd_pkg.sv
rtl/msrd_ram.sv
rtl/msrd_div.sv
rtl/max_sample_raster_downscale_core.sv
dv/max_sample_raster_downscale_core_tb.sv
